>>> hw/rtl/lzd_pkg.sv
// ----------------------------------------------------------------------------
// LZSS decompressor package
// Shared types and constants for the LZSS decompressor.
// ----------------------------------------------------------------------------
package lzd_pkg;

  localparam int BYTE_W   = 8;
  localparam int LEN_W    = 5;
  localparam int MAX_RUN  = 18;
  localparam int QDEPTH   = 2;
  localparam int QCNT_W   = 2;
  localparam int FLAG_W   = 16;
  localparam int FLAG_BIT = 8;

  localparam logic [BYTE_W-1:0] FLAG_FILL = 8'hff;

  typedef enum logic [1:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_COPY
  } st_t;

  typedef enum logic [1:0] {
    PH_BOUNDARY,
    PH_FLAG_LOADED,
    PH_MATCH_HI
  } phase_t;

  typedef enum logic [1:0] {
    KIND_FLAG,
    KIND_LITERAL,
    KIND_POS_LO,
    KIND_POS_HI
  } kind_t;

  typedef struct packed {
    logic              push;
    logic              last;
    logic [BYTE_W-1:0] data;
  } outq_push_t;

endpackage

>>> hw/rtl/lzd_window.sv
// ----------------------------------------------------------------------------
// LZSS window memory
// Single-port-write, single-port-read history RAM with registered read data.
// ----------------------------------------------------------------------------
module lzd_window
  import lzd_pkg::*;
#(
  parameter int AW = 12
) (
  input  logic              clk,
  input  logic              we,
  input  logic [AW-1:0]     waddr,
  input  logic [BYTE_W-1:0] wdata,
  input  logic              re,
  input  logic [AW-1:0]     raddr,
  output logic [BYTE_W-1:0] rdata
);

  logic [BYTE_W-1:0] mem [2**AW];
  logic [BYTE_W-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

>>> hw/rtl/lzd_outq.sv
// ----------------------------------------------------------------------------
// LZSS output queue
// Two-entry result queue that decouples the copy engine from the sink.
// ----------------------------------------------------------------------------
module lzd_outq
  import lzd_pkg::*;
(
  input  logic              clk,
  input  logic              rst_n,
  input  outq_push_t        push,
  output logic [QCNT_W-1:0] count,
  output logic              pop,
  output logic              out_tvalid,
  input  logic              out_tready,
  output logic [BYTE_W-1:0] out_byte,
  output logic              out_last
);

  logic [QCNT_W-1:0] count_r, count_nxt;
  logic [BYTE_W:0]   slot0_r, slot0_nxt;
  logic [BYTE_W:0]   slot1_r, slot1_nxt;
  logic [BYTE_W:0]   din;

  assign out_tvalid = (count_r != '0);
  assign pop        = out_tvalid && out_tready;
  assign din        = {push.last, push.data};

  always_comb begin
    count_nxt = count_r;
    slot0_nxt = slot0_r;
    slot1_nxt = slot1_r;
    case ({push.push, pop})
      2'b10: begin
        if (count_r == '0) begin
          slot0_nxt = din;
        end else begin
          slot1_nxt = din;
        end
        count_nxt = count_r + QCNT_W'(1);
      end
      2'b01: begin
        slot0_nxt = slot1_r;
        count_nxt = count_r - QCNT_W'(1);
      end
      2'b11: begin
        if (count_r == QCNT_W'(1)) begin
          slot0_nxt = din;
        end else begin
          slot0_nxt = slot1_r;
          slot1_nxt = din;
        end
      end
      default: begin
        count_nxt = count_r;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r <= '0;
    end else begin
      count_r <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    slot0_r <= slot0_nxt;
    slot1_r <= slot1_nxt;
  end

  assign count    = count_r;
  assign out_byte = slot0_r[BYTE_W-1:0];
  assign out_last = slot0_r[BYTE_W];

endmodule

>>> hw/rtl/lzd_ctrl.sv
// ----------------------------------------------------------------------------
// LZSS decompressor control
// Parses flag, literal and match bytes, sequences the match copy through the
// window memory with write forwarding, and runs the window clearing pass.
// ----------------------------------------------------------------------------
module lzd_ctrl
  import lzd_pkg::*;
#(
  parameter int AW              = 12,
  parameter int MATCH_THRESHOLD = 2
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_tvalid,
  output logic              in_tready,
  input  logic [BYTE_W-1:0] in_byte,
  input  logic              in_new_stream,
  input  logic [QCNT_W-1:0] q_count,
  input  logic              q_pop,
  output outq_push_t        q_push,
  output logic              mem_we,
  output logic [AW-1:0]     mem_waddr,
  output logic [BYTE_W-1:0] mem_wdata,
  output logic              mem_re,
  output logic [AW-1:0]     mem_raddr,
  input  logic [BYTE_W-1:0] mem_rdata
);

  st_t               state_r, state_nxt;
  phase_t            phase_r, phase_nxt;
  logic [FLAG_W-1:0] flag_shift_r, flag_shift_nxt;
  logic [AW-1:0]     wptr_r, wptr_nxt;
  logic [AW-1:0]     src_r, src_nxt;
  logic [AW-1:0]     clr_cnt_r, clr_cnt_nxt;
  logic [BYTE_W-1:0] pos_low_r, pos_low_nxt;
  logic [LEN_W-1:0]  cnt_r, cnt_nxt;
  logic              cleared_r, cleared_nxt;
  logic              rd_valid_r, rd_last_r, fwd_r;
  logic [BYTE_W-1:0] fwd_data_r;

  logic [FLAG_W-1:0] fs_use;
  kind_t             kind;
  logic [QCNT_W:0]   count_next;
  logic              idle_free, accept, start_clear, issue, last_issue, is_lit;
  logic [11:0]       pos_full;
  logic [LEN_W-1:0]  len_raw, len_sat;
  logic [BYTE_W-1:0] copy_byte;

  assign count_next  = {1'b0, q_count} + (QCNT_W+1)'(rd_valid_r) - (QCNT_W+1)'(q_pop);
  assign idle_free   = (state_r == ST_IDLE) && !rd_valid_r && (q_count != QCNT_W'(QDEPTH));
  assign start_clear = (state_r == ST_IDLE) && !rd_valid_r && in_tvalid && in_new_stream
                       && !cleared_r;
  assign in_tready   = idle_free && !(in_new_stream && !cleared_r);
  assign accept      = in_tvalid && in_tready;
  assign issue       = (state_r == ST_COPY) && (count_next <= (QCNT_W+1)'(1));
  assign last_issue  = issue && (cnt_r == LEN_W'(1));
  assign copy_byte   = fwd_r ? fwd_data_r : mem_rdata;

  assign pos_full = {in_byte[7:4], pos_low_r};
  assign len_raw  = LEN_W'(in_byte[3:0]) + LEN_W'(MATCH_THRESHOLD + 1);
  assign len_sat  = (len_raw > LEN_W'(MAX_RUN)) ? LEN_W'(MAX_RUN) : len_raw;

  always_comb begin
    fs_use = (phase_r == PH_FLAG_LOADED) ? flag_shift_r : {1'b0, flag_shift_r[FLAG_W-1:1]};
    unique case (phase_r)
      PH_MATCH_HI:    kind = KIND_POS_HI;
      PH_FLAG_LOADED: kind = fs_use[0] ? KIND_LITERAL : KIND_POS_LO;
      default: begin
        if (!fs_use[FLAG_BIT]) begin
          kind = KIND_FLAG;
        end else begin
          kind = fs_use[0] ? KIND_LITERAL : KIND_POS_LO;
        end
      end
    endcase
  end

  assign is_lit = accept && (kind == KIND_LITERAL);

  // next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_CLEAR: begin
        if (&clr_cnt_r) begin
          state_nxt = ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (start_clear) begin
          state_nxt = ST_CLEAR;
        end else if (accept && (kind == KIND_POS_HI)) begin
          state_nxt = ST_COPY;
        end
      end
      ST_COPY: begin
        if (last_issue) begin
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_CLEAR;
    endcase
  end

  // memory and queue drive
  always_comb begin
    mem_we      = 1'b0;
    mem_waddr   = wptr_r;
    mem_wdata   = in_byte;
    q_push.push = 1'b0;
    q_push.last = 1'b1;
    q_push.data = in_byte;
    if (state_r == ST_CLEAR) begin
      mem_we    = 1'b1;
      mem_waddr = clr_cnt_r;
      mem_wdata = '0;
    end else if (rd_valid_r) begin
      mem_we      = 1'b1;
      mem_wdata   = copy_byte;
      q_push.push = 1'b1;
      q_push.last = rd_last_r;
      q_push.data = copy_byte;
    end else if (is_lit) begin
      mem_we      = 1'b1;
      q_push.push = 1'b1;
    end
    mem_re    = issue;
    mem_raddr = src_r;
  end

  // datapath
  always_comb begin
    phase_nxt      = phase_r;
    flag_shift_nxt = flag_shift_r;
    wptr_nxt       = wptr_r;
    src_nxt        = src_r;
    cnt_nxt        = cnt_r;
    pos_low_nxt    = pos_low_r;
    clr_cnt_nxt    = clr_cnt_r;
    cleared_nxt    = cleared_r;

    if (state_r == ST_CLEAR) begin
      clr_cnt_nxt = clr_cnt_r + AW'(1);
      if (&clr_cnt_r) begin
        cleared_nxt = 1'b1;
      end
    end

    if (start_clear) begin
      phase_nxt      = PH_BOUNDARY;
      flag_shift_nxt = '0;
      wptr_nxt       = '0;
      pos_low_nxt    = '0;
      clr_cnt_nxt    = '0;
      cleared_nxt    = 1'b0;
    end else if (accept) begin
      cleared_nxt = 1'b0;
      unique case (kind)
        KIND_FLAG: begin
          flag_shift_nxt = {FLAG_FILL, in_byte};
          phase_nxt      = PH_FLAG_LOADED;
        end
        KIND_LITERAL: begin
          flag_shift_nxt = fs_use;
          phase_nxt      = PH_BOUNDARY;
        end
        KIND_POS_LO: begin
          flag_shift_nxt = fs_use;
          pos_low_nxt    = in_byte;
          phase_nxt      = PH_MATCH_HI;
        end
        KIND_POS_HI: begin
          src_nxt   = pos_full[AW-1:0];
          cnt_nxt   = len_sat;
          phase_nxt = PH_BOUNDARY;
        end
        default: phase_nxt = PH_BOUNDARY;
      endcase
    end

    if (issue) begin
      src_nxt = src_r + AW'(1);
      cnt_nxt = cnt_r - LEN_W'(1);
    end

    if ((state_r != ST_CLEAR) && (rd_valid_r || is_lit)) begin
      wptr_nxt = wptr_r + AW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= ST_CLEAR;
      phase_r      <= PH_BOUNDARY;
      flag_shift_r <= '0;
      wptr_r       <= '0;
      clr_cnt_r    <= '0;
      cleared_r    <= 1'b0;
      rd_valid_r   <= 1'b0;
      pos_low_r    <= '0;
    end else begin
      state_r      <= state_nxt;
      phase_r      <= phase_nxt;
      flag_shift_r <= flag_shift_nxt;
      wptr_r       <= wptr_nxt;
      clr_cnt_r    <= clr_cnt_nxt;
      cleared_r    <= cleared_nxt;
      rd_valid_r   <= issue;
      pos_low_r    <= pos_low_nxt;
    end
  end

  always_ff @(posedge clk) begin
    src_r      <= src_nxt;
    cnt_r      <= cnt_nxt;
    rd_last_r  <= last_issue;
    fwd_r      <= rd_valid_r && (src_r == wptr_r);
    fwd_data_r <= copy_byte;
  end

endmodule

>>> hw/rtl/lzss_decompressor_top.sv
// A literal byte is pushed into the output queue in the cycle it is accepted;
// a match's first byte is read from the window RAM after its second input byte
// and pushed from the registered read data. Input bytes are taken one per cycle
// while idle with queue room; a match copies one byte per cycle via the RAM port
// while the queue has room. Reset and new_stream run a window clearing pass.
// ----------------------------------------------------------------------------
// LZSS decompressor top level
// Byte-serial LZSS decoder with a sliding window held in on-chip RAM.
// ----------------------------------------------------------------------------
module lzss_decompressor_top
  import lzd_pkg::*;
#(
  parameter int WINDOW_SIZE     = 4096,
  parameter int MATCH_THRESHOLD = 2
) (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_tvalid,
  output logic       in_tready,
  input  logic [7:0] in_tdata,   // [7:0] stream_byte
  input  logic       in_tuser,   // [0] new_stream
  output logic       out_tvalid,
  input  logic       out_tready,
  output logic [7:0] out_tdata,  // [7:0] out_byte
  output logic       out_tlast
);

  localparam int AW = $clog2(WINDOW_SIZE);

  outq_push_t        q_push;
  logic [QCNT_W-1:0] q_count;
  logic              q_pop;
  logic              mem_we, mem_re;
  logic [AW-1:0]     mem_waddr, mem_raddr;
  logic [BYTE_W-1:0] mem_wdata, mem_rdata;

  lzd_ctrl #(
    .AW              (AW),
    .MATCH_THRESHOLD (MATCH_THRESHOLD)
  ) u_ctrl (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_tvalid     (in_tvalid),
    .in_tready     (in_tready),
    .in_byte       (in_tdata),
    .in_new_stream (in_tuser),
    .q_count       (q_count),
    .q_pop         (q_pop),
    .q_push        (q_push),
    .mem_we        (mem_we),
    .mem_waddr     (mem_waddr),
    .mem_wdata     (mem_wdata),
    .mem_re        (mem_re),
    .mem_raddr     (mem_raddr),
    .mem_rdata     (mem_rdata)
  );

  lzd_window #(
    .AW (AW)
  ) u_window (
    .clk   (clk),
    .we    (mem_we),
    .waddr (mem_waddr),
    .wdata (mem_wdata),
    .re    (mem_re),
    .raddr (mem_raddr),
    .rdata (mem_rdata)
  );

  lzd_outq u_outq (
    .clk        (clk),
    .rst_n      (rst_n),
    .push       (q_push),
    .count      (q_count),
    .pop        (q_pop),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_byte   (out_tdata),
    .out_last   (out_tlast)
  );

endmodule
